// File: hdl/deq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue package
// Sizes, request and status codes, and the structs that pass between the
// queue control and the top level.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned SUM_W    = ADDR_W + 1;
  localparam int unsigned FILL_W   = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_PEEK_FRONT = 3'd4,
    CMD_PEEK_BACK  = 3'd5,
    CMD_SIZE       = 3'd6,
    CMD_CLEAR      = 3'd7
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // One access to the ring memory.
  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } ram_req_t;

  // A request whose result waits for the memory read data.
  typedef struct packed {
    logic              valid;
    logic              rd_sel;
    status_t           status;
    logic [FILL_W-1:0] fill;
  } pend_t;

endpackage

// File: hdl/deq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module deq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/deq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue control
// Holds the head index and fill count, decodes each request into at most one ring
// memory access and keeps the pending result until the read data arrives.
// ----------------------------------------------------------------------------
module deq_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic [deq_pkg::CMD_W-1:0]      in_cmd,
  input  logic [deq_pkg::DATA_W-1:0]     in_push_value,
  input  logic                           advance,
  output logic                           in_stall,
  output deq_pkg::ram_req_t              ram_req,
  output deq_pkg::pend_t                 pend
);
  import deq_pkg::*;

  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  pend_t             pend_r, pend_nxt;

  logic              accept;
  logic              empty;
  logic              full;
  cmd_t              cmd;
  logic [ADDR_W-1:0] head_dec;
  logic [ADDR_W-1:0] head_inc;
  logic [SUM_W-1:0]  push_sum;
  logic [SUM_W-1:0]  back_sum;
  logic [ADDR_W-1:0] push_slot;
  logic [ADDR_W-1:0] back_slot;
  status_t           status;
  logic              rd_sel;

  // The sum of two ring positions stays below twice the capacity.
  function automatic logic [ADDR_W-1:0] ring_wrap(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] r;
    begin
      r = (s >= SUM_W'(CAPACITY)) ? s - SUM_W'(CAPACITY) : s;
      return r[ADDR_W-1:0];
    end
  endfunction

  assign in_stall = pend_r.valid && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd       = cmd_t'(in_cmd);
    empty     = (fill_r == '0);
    full      = (fill_r >= FILL_W'(CAPACITY));
    head_dec  = (head_r == '0) ? ADDR_W'(CAPACITY - 1) : head_r - 1'b1;
    head_inc  = (head_r == ADDR_W'(CAPACITY - 1)) ? '0 : head_r + 1'b1;
    push_sum  = SUM_W'(head_r) + SUM_W'(fill_r);
    back_sum  = push_sum - 1'b1;
    push_slot = ring_wrap(push_sum);
    back_slot = ring_wrap(back_sum);

    head_nxt      = head_r;
    fill_nxt      = fill_r;
    status        = ST_OK;
    rd_sel        = 1'b0;
    ram_req.we    = 1'b0;
    ram_req.re    = 1'b0;
    ram_req.addr  = head_r;
    ram_req.wdata = in_push_value;

    case (cmd)
      CMD_PUSH_FRONT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ram_req.we   = accept;
          ram_req.addr = head_dec;
          head_nxt     = head_dec;
          fill_nxt     = fill_r + 1'b1;
        end
      end
      CMD_PUSH_BACK: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          ram_req.we   = accept;
          ram_req.addr = push_slot;
          fill_nxt     = fill_r + 1'b1;
        end
      end
      CMD_POP_FRONT, CMD_PEEK_FRONT: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          ram_req.re   = accept;
          ram_req.addr = head_r;
          rd_sel       = 1'b1;
          if (cmd == CMD_POP_FRONT) begin
            head_nxt = head_inc;
            fill_nxt = fill_r - 1'b1;
          end
        end
      end
      CMD_POP_BACK, CMD_PEEK_BACK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          ram_req.re   = accept;
          ram_req.addr = back_slot;
          rd_sel       = 1'b1;
          if (cmd == CMD_POP_BACK) begin
            fill_nxt = fill_r - 1'b1;
          end
        end
      end
      CMD_SIZE: begin
      end
      CMD_CLEAR: begin
        head_nxt = '0;
        fill_nxt = '0;
      end
      default: begin
      end
    endcase

    if (!accept) begin
      head_nxt = head_r;
      fill_nxt = fill_r;
    end

    if (accept) begin
      pend_nxt.valid  = 1'b1;
      pend_nxt.rd_sel = rd_sel;
      pend_nxt.status = status;
      pend_nxt.fill   = fill_nxt;
    end else if (advance) begin
      pend_nxt       = pend_r;
      pend_nxt.valid = 1'b0;
    end else begin
      pend_nxt = pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      fill_r       <= '0;
      pend_r.valid <= 1'b0;
    end else begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
      pend_r <= pend_nxt;
    end
  end

  assign pend = pend_r;

endmodule

// File: hdl/double_ended_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue unit
// Bounded deque of 32-bit words in a ring memory with head index and count.
// The result passes the memory read, then the output register. One request per
// cycle unless the output stalls; head and count update at acceptance.
// Reset clears head and count; the ring memory is not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [deq_pkg::CMD_W-1:0]      in_cmd,
  input  logic [deq_pkg::DATA_W-1:0]     in_push_value,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [deq_pkg::DATA_W-1:0]     out_read_value,
  output logic [deq_pkg::STATUS_W-1:0]   out_status,
  output logic [deq_pkg::COUNT_W-1:0]    out_count
);
  import deq_pkg::*;

  ram_req_t           ram_req;
  pend_t              pend;
  logic               advance;
  logic [DATA_W-1:0]  rdata;

  logic               out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]  out_read_value_r;
  status_t            out_status_r;
  logic [COUNT_W-1:0] out_count_r;

  assign advance = !out_valid_r || !out_stall;

  deq_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_cmd        (in_cmd),
    .in_push_value (in_push_value),
    .advance       (advance),
    .in_stall      (in_stall),
    .ram_req       (ram_req),
    .pend          (pend)
  );

  deq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ring (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.addr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.addr),
    .rdata (rdata)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = pend.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && pend.valid) begin
      out_read_value_r <= pend.rd_sel ? rdata : '0;
      out_status_r     <= pend.status;
      out_count_r      <= COUNT_W'(pend.fill);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_status     = out_status_r;
  assign out_count      = out_count_r;

  // The stored word count never goes past the capacity.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend.valid |-> pend.fill <= FILL_W'(CAPACITY))
    else $error("fill count above capacity");

  // A failed request never takes its result from the ring memory.
  a_err_no_read: assert property (@(posedge clk) disable iff (!rst_n)
    pend.valid && pend.status != ST_OK |-> !pend.rd_sel)
    else $error("error result selects ring data");

  // An empty status always carries a zero word.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == ST_EMPTY |-> out_read_value_r == '0)
    else $error("empty result with nonzero word");

  // A pending result that cannot move on is kept for the next cycle.
  a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
    pend.valid && !advance |=> pend.valid && $stable(pend.fill))
    else $error("pending result lost");

endmodule

// File: bench/tb_double_ended_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Double-ended queue unit testbench
// Drives push, pop, peek, size and clear requests from both ends and tracks
// the queue contents in a scoreboard. Each result is checked against the
// word, status and count that the tracked contents give. The run covers the
// empty and full cases and a long receiver hold. Random idling is used on
// both channels.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_unit;
  import deq_pkg::*;

  typedef struct {
    logic [DATA_W-1:0]   read_value;
    status_t             status;
    logic [COUNT_W-1:0]  count;
  } deq_result_t;

  class deque_scoreboard;
    logic [DATA_W-1:0] words[$];   // index 0 is the front
    deq_result_t       expected[$];
    int                errors = 0;

    function void note_request(cmd_t c, logic [DATA_W-1:0] v);
      deq_result_t r;
      r.read_value = '0;
      r.status     = ST_OK;
      case (c)
        CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
          if (words.size() >= CAPACITY) r.status = ST_FULL;
          else if (c == CMD_PUSH_FRONT) words.insert(0, v);
          else words.insert(words.size(), v);
        end
        CMD_POP_FRONT, CMD_PEEK_FRONT: begin
          if (words.size() == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.read_value = words[0];
            if (c == CMD_POP_FRONT) words.delete(0);
          end
        end
        CMD_POP_BACK, CMD_PEEK_BACK: begin
          if (words.size() == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.read_value = words[words.size() - 1];
            if (c == CMD_POP_BACK) words.delete(words.size() - 1);
          end
        end
        CMD_CLEAR: begin
          words.delete();
        end
        default: begin
        end
      endcase
      r.count = COUNT_W'(words.size());
      expected.insert(expected.size(), r);
    endfunction

    function void check_result(logic [DATA_W-1:0] rd, logic [STATUS_W-1:0] st,
                               logic [COUNT_W-1:0] cnt);
      deq_result_t r;
      if (expected.size() == 0) begin
        $display("%0t: result with nothing outstanding (read_value %h status %0d count %0d)",
                 $time, rd, st, cnt);
        errors++;
        return;
      end
      r = expected[0];
      expected.delete(0);
      if (rd !== r.read_value) begin
        $display("%0t: read_value expected %h actual %h", $time, r.read_value, rd);
        errors++;
      end
      if (st !== r.status) begin
        $display("%0t: status expected %0d actual %0d", $time, r.status, st);
        errors++;
      end
      if (cnt !== r.count) begin
        $display("%0t: count expected %0d actual %0d", $time, r.count, cnt);
        errors++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [CMD_W-1:0]    in_cmd;
  logic [DATA_W-1:0]   in_push_value;
  logic                out_valid;
  logic                out_stall;
  logic [DATA_W-1:0]   out_read_value;
  logic [STATUS_W-1:0] out_status;
  logic [COUNT_W-1:0]  out_count;

  deque_scoreboard sb = new();
  bit              calm = 1'b0;      // no idling on either side while set
  bit              hold_req = 1'b0;  // asks the receiver for one long hold

  double_ended_queue_unit u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_push_value  (in_push_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_value (out_read_value),
    .out_status     (out_status),
    .out_count      (out_count)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm) return 0;
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_request(cmd_t c, logic [DATA_W-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= c;
    in_push_value <= v;
    do @(posedge clk); while (in_stall);
    sb.note_request(c, v);
  endtask

  task automatic send_random_request();
    int   roll;
    cmd_t c;
    roll = $urandom_range(0, 99);
    if (roll < 22)      c = CMD_PUSH_FRONT;
    else if (roll < 44) c = CMD_PUSH_BACK;
    else if (roll < 58) c = CMD_POP_FRONT;
    else if (roll < 72) c = CMD_POP_BACK;
    else if (roll < 81) c = CMD_PEEK_FRONT;
    else if (roll < 90) c = CMD_PEEK_BACK;
    else if (roll < 98) c = CMD_SIZE;
    else                c = CMD_CLEAR;
    send_request(c, $urandom);
  endtask

  // Result side: checks every accepted result and stalls at random.
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        sb.check_result(out_read_value, out_status, out_count);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = 300;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
        stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_cmd        <= CMD_SIZE;
    in_push_value <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty cases, extreme words, both ends, clear.
    send_request(CMD_SIZE, 32'h0);
    send_request(CMD_POP_FRONT, 32'h0);
    send_request(CMD_POP_BACK, 32'h0);
    send_request(CMD_PEEK_FRONT, 32'h0);
    send_request(CMD_PEEK_BACK, 32'h0);
    send_request(CMD_PUSH_FRONT, 32'h7FFF_FFFF);
    send_request(CMD_PUSH_BACK, 32'h8000_0000);
    send_request(CMD_PUSH_FRONT, 32'hFFFF_FFFF);
    send_request(CMD_PUSH_BACK, 32'h0000_0000);
    send_request(CMD_PEEK_FRONT, 32'h0);
    send_request(CMD_PEEK_BACK, 32'h0);
    send_request(CMD_SIZE, 32'hFFFF_FFFF);
    send_request(CMD_POP_BACK, 32'h0);
    send_request(CMD_POP_FRONT, 32'h0);
    send_request(CMD_PEEK_FRONT, 32'h0);
    send_request(CMD_PEEK_BACK, 32'h0);
    send_request(CMD_POP_FRONT, 32'h0);
    send_request(CMD_POP_BACK, 32'h0);
    send_request(CMD_POP_FRONT, 32'h0);
    send_request(CMD_PUSH_BACK, 32'h0000_0001);
    send_request(CMD_PUSH_FRONT, 32'hFFFF_FFFE);
    send_request(CMD_CLEAR, 32'h0);
    send_request(CMD_PEEK_BACK, 32'h0);
    send_request(CMD_SIZE, 32'h0);

    // Fill to capacity from both ends while the receiver holds off for a
    // long stretch, then push into a full queue, take a few words from
    // both ends and clear it.
    hold_req = 1'b1;
    while (sb.words.size() < CAPACITY)
      send_request($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, $urandom);
    send_request(CMD_PUSH_FRONT, $urandom);
    send_request(CMD_PUSH_BACK, $urandom);
    send_request(CMD_PEEK_FRONT, 32'h0);
    send_request(CMD_PEEK_BACK, 32'h0);
    send_request(CMD_SIZE, 32'h0);
    repeat (8)
      send_request($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK, $urandom);
    send_request(CMD_CLEAR, 32'h0);
    send_request(CMD_POP_BACK, 32'h0);
    send_request(CMD_PEEK_FRONT, 32'h0);

    for (int i = 0; i < 600; i++) begin
      calm = ((i % 150) < 40);
      send_random_request();
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (sb.expected.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.expected.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("%0t: timeout", $time);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
